// ----- hdl/rom_ram_bank_controller_defines.svh -----
// Assertion macros shared by the bank controller RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef ROM_RAM_BANK_CONTROLLER_DEFINES_SVH
`define ROM_RAM_BANK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RRBC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RRBC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/rrbc_pkg.sv -----
// Types, codes and constants of the cartridge bank controller.
// Used by the channel interfaces, the top level and the testbench.
package rrbc_pkg;

   localparam int RAM_BANKS_DEFAULT = 4;
   localparam int BANK_BYTES        = 8192;
   localparam int BANK_ADDR_BITS    = $clog2(BANK_BYTES);
   localparam int ROM_BANK_BITS     = 5;
   localparam int RAM_SEL_BITS      = 2;

   localparam int ADDRESS_BITS     = 16;
   localparam int DATA_BITS        = 8;
   localparam int ROM_ADDRESS_BITS = 20;
   localparam int SOURCE_BITS      = 2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 3;
   localparam int SIZE_CODE_BITS = 3;

   localparam logic [DATA_BITS-1:0]        OPEN_BUS_BYTE   = 8'hFF;
   localparam logic [3:0]                  RAM_ENABLE_KEY  = 4'hA;
   localparam logic [ROM_ADDRESS_BITS-1:0] ROM_WINDOW_BASE = 20'h04000;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } opcode_type;

   typedef enum logic [SOURCE_BITS-1:0] {
      SRC_ROM   = 2'd0,
      SRC_RAM   = 2'd1,
      SRC_OPEN  = 2'd2,
      SRC_WRITE = 2'd3
   } src_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MAPPER_ENABLE   = 2'd0,
      CSR_RAM_SIZE_CODE   = 2'd1,
      CSR_BATTERY_PRESENT = 2'd2
   } csr_index_type;

   // Address bits 15:13 select an 8 KiB region of the CPU bus.
   typedef enum logic [2:0] {
      REGION_RAM_ENABLE = 3'd0,
      REGION_ROM_BANK   = 3'd1,
      REGION_RAM_BANK   = 3'd2,
      REGION_BANK_MODE  = 3'd3,
      REGION_EXT_RAM    = 3'd5
   } region_type;

   typedef enum logic [SIZE_CODE_BITS-1:0] {
      SIZE_ONE_BANK = 3'd2,
      SIZE_ALL_LOW  = 3'd3,
      SIZE_ALL_HIGH = 3'd5
   } size_code_type;

   typedef struct packed {
      logic [DATA_BITS-1:0]        read_data;
      logic [ROM_ADDRESS_BITS-1:0] rom_address;
      src_type                     source;
      logic                        save_request;
   } rsp_fields_type;

   typedef struct packed {
      logic           use_ram;
      rsp_fields_type fields;
   } stage_type;

   function automatic logic bank_present(input logic [RAM_SEL_BITS-1:0]   bank,
                                         input logic [SIZE_CODE_BITS-1:0] size_code,
                                         input int                        bank_limit);
      logic present;
      present = 1'b0;
      if (int'(bank) < bank_limit) begin
         if (size_code == SIZE_ONE_BANK) begin
            present = (bank == '0);
         end else begin
            present = (size_code >= SIZE_ALL_LOW) && (size_code <= SIZE_ALL_HIGH);
         end
      end
      return present;
   endfunction

endpackage

// ----- hdl/rrbc_ifs.sv -----
// Valid/ready channel interfaces for bus transactions and their results.
// Depends on rrbc_pkg for the field widths.
interface rrbc_req_if import rrbc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic [ADDRESS_BITS-1:0] address;
   logic [DATA_BITS-1:0]    write_data;

   modport source (output valid, output opcode, output address, output write_data,
                   input ready);
   modport sink   (input valid, input opcode, input address, input write_data,
                   output ready);
endinterface

interface rrbc_rsp_if import rrbc_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [DATA_BITS-1:0]        read_data;
   logic [ROM_ADDRESS_BITS-1:0] rom_address;
   logic [SOURCE_BITS-1:0]      data_source;
   logic                        save_request;

   modport source (output valid, output read_data, output rom_address,
                   output data_source, output save_request, input ready);
   modport sink   (input valid, input read_data, input rom_address,
                   input data_source, input save_request, output ready);
endinterface

// ----- hdl/rrbc_ram.sv -----
// Generic single-port synchronous RAM with a registered, enabled read.
// Standalone; used for the battery-backed cartridge RAM.
module rrbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_array [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_array[addr] <= write_data;
      end
      if (read_enable) begin
         read_data <= mem_array[addr];
      end
   end

endmodule

// ----- hdl/rom_ram_bank_controller.sv -----
// Cartridge ROM/RAM bank controller. A transaction passes through stage 1 and then the output
// register, which holds its result; one transaction per cycle is sustained while rsp_chan.ready stays high.
// Reset is synchronous: control registers return to their defaults and the RAM is then
// cleared by a pass over all RAM_BANKS*8192 entries (32768 by default), during which req_chan.ready
// stays low. Configuration writes are taken at any time, including during that pass.
`include "rom_ram_bank_controller_defines.svh"

module rom_ram_bank_controller import rrbc_pkg::*; #(
   parameter int RAM_BANKS = RAM_BANKS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   rrbc_req_if.sink                  req_chan,
   rrbc_rsp_if.source                rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int RAM_DEPTH = RAM_BANKS * BANK_BYTES;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   // Configuration registers.
   logic                      mapper_enable_ff, mapper_enable_in;
   logic [SIZE_CODE_BITS-1:0] ram_size_code_ff, ram_size_code_in;
   logic                      battery_present_ff, battery_present_in;

   // Mapper state.
   logic                     ram_enable_ff, ram_enable_in;
   logic [ROM_BANK_BITS-1:0] rom_bank_ff, rom_bank_in;
   logic [RAM_SEL_BITS-1:0]  ram_bank_select_ff, ram_bank_select_in;
   logic                     bank_mode_ff, bank_mode_in;
   logic [RAM_SEL_BITS-1:0]  active_ram_bank_ff, active_ram_bank_in;
   logic                     dirty_ff, dirty_in;

   // RAM clearing pass.
   logic              clear_active_ff, clear_active_in;
   logic [RAM_AW-1:0] clear_addr_ff, clear_addr_in;

   // Pipeline: stage 1 waits on the RAM read, the output register holds the result.
   logic           s1_valid_ff, s1_valid_in;
   stage_type      s1_ff, s1_in;
   logic           out_valid_ff, out_valid_in;
   rsp_fields_type out_ff, out_in;

   logic           req_accept;
   logic           out_free;
   logic           s1_adv;
   logic           ram_open;
   stage_type      st0;
   logic           item_ram_write;
   region_type     region;
   logic [RAM_AW-1:0] item_idx;

   logic                 ram_we;
   logic                 ram_re;
   logic [RAM_AW-1:0]    ram_addr;
   logic [DATA_BITS-1:0] ram_wdata;
   logic [DATA_BITS-1:0] ram_rdata;

   // Stage 1 moves on whenever the output register is empty or being drained, so a new
   // transaction can enter every cycle while the consumer keeps rsp_chan.ready high.
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && out_free;
   assign req_chan.ready = !clear_active_ff && (!s1_valid_ff || out_free);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign region   = region_type'(req_chan.address[ADDRESS_BITS-1:BANK_ADDR_BITS]);
   assign ram_open = ram_enable_ff &&
                     bank_present(active_ram_bank_ff, ram_size_code_ff, RAM_BANKS);
   assign item_idx = RAM_AW'({active_ram_bank_ff, req_chan.address[BANK_ADDR_BITS-1:0]});

   always_comb begin
      mapper_enable_in   = mapper_enable_ff;
      ram_size_code_in   = ram_size_code_ff;
      battery_present_in = battery_present_ff;
      ram_enable_in      = ram_enable_ff;
      rom_bank_in        = rom_bank_ff;
      ram_bank_select_in = ram_bank_select_ff;
      bank_mode_in       = bank_mode_ff;
      active_ram_bank_in = active_ram_bank_ff;
      dirty_in           = dirty_ff;
      clear_active_in    = clear_active_ff;
      clear_addr_in      = clear_addr_ff;
      item_ram_write     = 1'b0;
      ram_re             = 1'b0;

      st0                = '0;
      st0.fields.source  = SRC_ROM;

      // Configuration writes; an index beyond the register list is dropped.
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAPPER_ENABLE:   mapper_enable_in   = csr_write_data[0];
            CSR_RAM_SIZE_CODE:   ram_size_code_in   = csr_write_data;
            CSR_BATTERY_PRESENT: battery_present_in = csr_write_data[0];
            default: ;
         endcase
      end

      if (req_chan.opcode == OP_READ) begin
         if (!mapper_enable_ff || (req_chan.address[ADDRESS_BITS-1:ADDRESS_BITS-2] == 2'b00)) begin
            // Fixed bank, or plain ROM: the address goes through untouched.
            st0.fields.rom_address = ROM_ADDRESS_BITS'(req_chan.address);
         end else if (region == REGION_EXT_RAM) begin
            if (ram_open) begin
               st0.use_ram       = 1'b1;
               st0.fields.source = SRC_RAM;
               ram_re            = req_accept;
            end else begin
               st0.fields.read_data = OPEN_BUS_BYTE;
               st0.fields.source    = SRC_OPEN;
            end
         end else begin
            // Switchable window; the unused upper regions alias onto it as well.
            st0.fields.rom_address = {1'b0, rom_bank_ff, {(ROM_ADDRESS_BITS-ROM_BANK_BITS-1){1'b0}}}
                                   + ROM_ADDRESS_BITS'(req_chan.address) - ROM_WINDOW_BASE;
         end
      end else begin
         st0.fields.source = SRC_WRITE;
         if (mapper_enable_ff) begin
            case (region)
               REGION_RAM_ENABLE: begin
                  if (req_accept) begin
                     ram_enable_in = (req_chan.write_data[3:0] == RAM_ENABLE_KEY);
                  end
               end
               REGION_ROM_BANK: begin
                  if (req_accept) begin
                     // A written zero selects bank one; the mask is applied after that.
                     rom_bank_in = (req_chan.write_data == '0) ? ROM_BANK_BITS'(1)
                                 : req_chan.write_data[ROM_BANK_BITS-1:0];
                  end
               end
               REGION_RAM_BANK: begin
                  if (bank_mode_ff) begin
                     st0.fields.save_request = dirty_ff;
                  end
                  if (req_accept) begin
                     ram_bank_select_in = req_chan.write_data[RAM_SEL_BITS-1:0];
                     if (bank_mode_ff) begin
                        active_ram_bank_in = req_chan.write_data[RAM_SEL_BITS-1:0];
                     end
                  end
               end
               REGION_BANK_MODE: begin
                  // Leaving mode one keeps the active bank where it was.
                  if (req_chan.write_data[0]) begin
                     st0.fields.save_request = dirty_ff;
                  end
                  if (req_accept) begin
                     bank_mode_in = req_chan.write_data[0];
                     if (req_chan.write_data[0]) begin
                        active_ram_bank_in = ram_bank_select_ff;
                     end
                  end
               end
               REGION_EXT_RAM: begin
                  if (req_accept && ram_open) begin
                     item_ram_write = 1'b1;
                     if (battery_present_ff) begin
                        dirty_in = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
      end

      // One entry per cycle is zeroed after reset; no transaction is taken meanwhile.
      if (clear_active_ff) begin
         clear_addr_in = clear_addr_ff + RAM_AW'(1);
         if (clear_addr_ff == RAM_AW'(RAM_DEPTH - 1)) begin
            clear_active_in = 1'b0;
         end
      end
   end

   // RAM port: the clearing pass owns it until done, then transactions do. A write lands at
   // the edge of acceptance, so a read accepted in the next cycle already sees the new byte.
   assign ram_we    = clear_active_ff || item_ram_write;
   assign ram_addr  = clear_active_ff ? clear_addr_ff : item_idx;
   assign ram_wdata = clear_active_ff ? '0 : req_chan.write_data;

   rrbc_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .read_enable  (ram_re),
      .addr         (ram_addr),
      .write_data   (ram_wdata),
      .read_data    (ram_rdata)
   );

   // The RAM read data register only changes on a new read, so it stays valid while stage 1
   // is stalled behind a full output register.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_in        = s1_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (s1_adv) begin
         out_valid_in = 1'b1;
         out_in       = s1_ff.fields;
         if (s1_ff.use_ram) begin
            out_in.read_data = ram_rdata;
         end
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_in       = st0;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mapper_enable_ff   <= 1'b0;
         ram_size_code_ff   <= '0;
         battery_present_ff <= 1'b0;
         ram_enable_ff      <= 1'b0;
         rom_bank_ff        <= ROM_BANK_BITS'(1);
         ram_bank_select_ff <= '0;
         bank_mode_ff       <= 1'b0;
         active_ram_bank_ff <= '0;
         dirty_ff           <= 1'b0;
         clear_active_ff    <= 1'b1;
         clear_addr_ff      <= '0;
         s1_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         mapper_enable_ff   <= mapper_enable_in;
         ram_size_code_ff   <= ram_size_code_in;
         battery_present_ff <= battery_present_in;
         ram_enable_ff      <= ram_enable_in;
         rom_bank_ff        <= rom_bank_in;
         ram_bank_select_ff <= ram_bank_select_in;
         bank_mode_ff       <= bank_mode_in;
         active_ram_bank_ff <= active_ram_bank_in;
         dirty_ff           <= dirty_in;
         clear_active_ff    <= clear_active_in;
         clear_addr_ff      <= clear_addr_in;
         s1_valid_ff        <= s1_valid_in;
         out_valid_ff       <= out_valid_in;
      end
   end

   // Payload registers carry no reset; their valid flags above qualify them.
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      out_ff <= out_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.read_data    = out_ff.read_data;
   assign rsp_chan.rom_address  = out_ff.rom_address;
   assign rsp_chan.data_source  = out_ff.source;
   assign rsp_chan.save_request = out_ff.save_request;

   // The clearing pass writes zeros every cycle and keeps transactions out.
   `RRBC_ASSERT_IMP(a_clear_owns_ram, clock, reset, clear_active_ff, !req_chan.ready && ram_we && (ram_wdata == '0), "clearing pass lost the RAM port")
   // A stalled stage 1 must keep its contents, since the RAM read is not repeated.
   `RRBC_ASSERT_NXT(a_s1_holds, clock, reset, s1_valid_ff && !out_free, s1_valid_ff && $stable(s1_ff), "stage 1 changed while stalled")
   // A RAM read is issued only for an accepted transaction and never with a write.
   `RRBC_ASSERT_IMP(a_read_on_accept, clock, reset, ram_re, req_accept && !ram_we, "RAM read without an accepted transaction")
   // Only writes can raise a save request.
   `RRBC_ASSERT_IMP(a_save_on_write, clock, reset, out_valid_ff && out_ff.save_request, out_ff.source == SRC_WRITE, "save request on a read result")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the cartridge ROM/RAM bank controller.
// Depends on rrbc_pkg, the channel interfaces in rrbc_ifs.sv and the controller RTL.

module testbench import rrbc_pkg::*; ();

   // One CPU bus transaction as the driver offers it.
   typedef struct {
      opcode_type              op;
      logic [ADDRESS_BITS-1:0] addr;
      logic [DATA_BITS-1:0]    data;
   } cart_access_type;

   // One setting of the three configuration registers.
   typedef struct {
      logic                      mapper;
      logic [SIZE_CODE_BITS-1:0] size_code;
      logic                      battery;
   } setting_type;

   logic clock;
   logic reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   rrbc_req_if req_if ();
   rrbc_rsp_if rsp_if ();

   rom_ram_bank_controller u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Transactions waiting to be offered, and results predicted for accepted ones.
   cart_access_type pending_access_q[$];
   rsp_fields_type  expected_rsp_q[$];

   int error_count   = 0;
   int rsp_count     = 0;
   int phase_items   = 0;
   int holdoff_left  = 0;
   int holdoffs_done = 0;
   logic req_fire    = 1'b0;
   logic in_reset    = 1'b1;

   // Both sides run without random idling while this window of responses passes.
   wire no_idle = (rsp_count >= 450) && (rsp_count < 600);

   // The receiver holds off once the response count passes each of these marks.
   int holdoff_marks [2] = '{150, 650};

   // A few RAM offsets that are hit often so that reads find bytes written earlier.
   logic [BANK_ADDR_BITS-1:0] hot_offsets [8] =
      '{13'h0000, 13'h1FFF, 13'h0123, 13'h0A5A, 13'h1000, 13'h0001, 13'h1555, 13'h0FFF};

   // Settings of the random phases; the extremes of every register are among them.
   setting_type phase_plan [11] = '{
      '{1'b1, 3'd3, 1'b1}, '{1'b1, 3'd2, 1'b0}, '{1'b1, 3'd5, 1'b1}, '{1'b1, 3'd4, 1'b0},
      '{1'b0, 3'd7, 1'b1}, '{1'b1, 3'd0, 1'b1}, '{1'b1, 3'd1, 1'b0}, '{1'b1, 3'd6, 1'b1},
      '{1'b1, 3'd7, 1'b0}, '{1'b1, 3'd2, 1'b1}, '{1'b1, 3'd3, 1'b0}
   };

   // Predictor copy of the configuration registers.
   logic                      cfg_mapper_enable = 1'b0;
   logic [SIZE_CODE_BITS-1:0] cfg_size_code     = '0;
   logic                      cfg_battery       = 1'b0;

   // Predictor copy of the controller state, at its reset values.
   logic                     ram_access_on = 1'b0;
   logic [ROM_BANK_BITS-1:0] rom_bank_sel  = 5'd1;
   logic [RAM_SEL_BITS-1:0]  ram_select    = '0;
   logic                     bank_mode_q   = 1'b0;
   logic [RAM_SEL_BITS-1:0]  active_bank   = '0;
   logic                     ram_dirty     = 1'b0;
   logic [DATA_BITS-1:0]     ram_image [RAM_BANKS_DEFAULT*BANK_BYTES];

   // The clock runs at 50 MHz.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Whether a RAM bank is fitted under the current size code.
   function automatic logic ram_bank_exists(input logic [RAM_SEL_BITS-1:0] bank);
      if (int'(bank) >= RAM_BANKS_DEFAULT) begin
         return 1'b0;
      end
      if (cfg_size_code == SIZE_ONE_BANK) begin
         return bank == '0;
      end
      return (cfg_size_code >= SIZE_ALL_LOW) && (cfg_size_code <= SIZE_ALL_HIGH);
   endfunction

   // Works out the result of one bus transaction and applies its effect on the state.
   function automatic rsp_fields_type predict_bus_access(input cart_access_type acc);
      rsp_fields_type res;
      logic [2:0] region;
      logic [14:0] ram_addr;
      region   = acc.addr[15:13];
      ram_addr = {active_bank, acc.addr[BANK_ADDR_BITS-1:0]};
      res = '0;
      res.source = SRC_ROM;
      if (acc.op == OP_READ) begin
         if (!cfg_mapper_enable || acc.addr < 16'h4000) begin
            // Fixed bank, or a plain ROM: the address goes through unchanged.
            res.rom_address = 20'(acc.addr);
         end else if (region == REGION_EXT_RAM) begin
            if (ram_access_on && ram_bank_exists(active_bank)) begin
               res.read_data = ram_image[ram_addr];
               res.source    = SRC_RAM;
            end else begin
               res.read_data = OPEN_BUS_BYTE;
               res.source    = SRC_OPEN;
            end
         end else begin
            // Every other read maps through the selected ROM bank, wrapping at 1 MiB.
            res.rom_address = {rom_bank_sel, 14'b0} + 20'(acc.addr) - ROM_WINDOW_BASE;
         end
      end else begin
         res.source = SRC_WRITE;
         if (cfg_mapper_enable) begin
            case (region)
               REGION_RAM_ENABLE: begin
                  ram_access_on = (acc.data[3:0] == RAM_ENABLE_KEY);
               end
               REGION_ROM_BANK: begin
                  // Zero turns into one before the mask, so 0x20 still selects bank 0.
                  rom_bank_sel = (acc.data == '0) ? 5'd1 : acc.data[ROM_BANK_BITS-1:0];
               end
               REGION_RAM_BANK: begin
                  ram_select = acc.data[RAM_SEL_BITS-1:0];
                  if (bank_mode_q) begin
                     res.save_request = ram_dirty;
                     active_bank      = ram_select;
                  end
               end
               REGION_BANK_MODE: begin
                  // Going back to mode zero leaves the active RAM bank where it was.
                  bank_mode_q = acc.data[0];
                  if (bank_mode_q) begin
                     res.save_request = ram_dirty;
                     active_bank      = ram_select;
                  end
               end
               REGION_EXT_RAM: begin
                  if (ram_access_on && ram_bank_exists(active_bank)) begin
                     ram_image[ram_addr] = acc.data;
                     // The dirty mark is sticky; only reset clears it.
                     if (cfg_battery) begin
                        ram_dirty = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
      return res;
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic queue_access(input opcode_type op, input logic [ADDRESS_BITS-1:0] addr,
                               input logic [DATA_BITS-1:0] data);
      cart_access_type acc;
      acc.op   = op;
      acc.addr = addr;
      acc.data = data;
      pending_access_q.push_back(acc);
      phase_items++;
   endtask

   // Writes one configuration register and mirrors it in the predictor.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         CSR_MAPPER_ENABLE:   cfg_mapper_enable = value[0];
         CSR_RAM_SIZE_CODE:   cfg_size_code     = value;
         CSR_BATTERY_PRESENT: cfg_battery       = value[0];
         default: begin
         end
      endcase
   endtask

   // The one-bit registers get random upper bits, which the block must ignore.
   task automatic apply_setting(input setting_type s);
      write_csr(CSR_MAPPER_ENABLE, {2'($urandom_range(3)), s.mapper});
      write_csr(CSR_RAM_SIZE_CODE, s.size_code);
      write_csr(CSR_BATTERY_PRESENT, {2'($urandom_range(3)), s.battery});
      @(posedge clock);
      phase_items = 0;
   endtask

   // Returns once every queued transaction has been accepted and answered.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_access_q.size() != 0 || req_if.valid || expected_rsp_q.size() != 0);
   endtask

   // Queues one short sequence: mostly well-formed RAM and banking sessions with random
   // content, with some ROM bank traffic and plain noise mixed in.
   task automatic queue_random_burst();
      int kind;
      logic [BANK_ADDR_BITS-1:0] offset;
      logic [DATA_BITS-1:0] value;
      kind = $urandom_range(99);
      if (kind < 45) begin
         // RAM session: enable, maybe pick a bank and mode, then reads and writes.
         value = ($urandom_range(99) < 85) ? {4'($urandom_range(15)), RAM_ENABLE_KEY}
                                           : 8'($urandom_range(255));
         queue_access(OP_WRITE, 16'($urandom_range(16'h1FFF)), value);
         if ($urandom_range(1) == 1) begin
            queue_access(OP_WRITE, 16'h4000 | 16'($urandom_range(16'h1FFF)),
                         8'($urandom_range(255)));
         end
         if ($urandom_range(2) == 0) begin
            queue_access(OP_WRITE, 16'h6000 | 16'($urandom_range(16'h1FFF)),
                         8'($urandom_range(255)));
         end
         repeat ($urandom_range(2, 8)) begin
            offset = ($urandom_range(3) != 0) ? hot_offsets[$urandom_range(7)]
                                              : 13'($urandom_range(16'h1FFF));
            queue_access(($urandom_range(1) == 1) ? OP_WRITE : OP_READ, 16'hA000 | 16'(offset),
                         8'($urandom_range(255)));
         end
      end else if (kind < 65) begin
         // ROM bank change, including the zero and 0x20 values, then banked reads.
         case ($urandom_range(3))
            0:       value = 8'h00;
            1:       value = 8'h20;
            default: value = 8'($urandom_range(255));
         endcase
         queue_access(OP_WRITE, 16'h2000 | 16'($urandom_range(16'h1FFF)), value);
         repeat ($urandom_range(2, 5)) begin
            queue_access(OP_READ, 16'($urandom_range(16'h4000, 16'hFFFF)),
                         8'($urandom_range(255)));
         end
      end else if (kind < 80) begin
         // Bank switching around a RAM write, so that switches meet a dirty RAM.
         queue_access(OP_WRITE, 16'h4000 | 16'($urandom_range(16'h1FFF)),
                      8'($urandom_range(255)));
         queue_access(OP_WRITE, 16'h6000 | 16'($urandom_range(16'h1FFF)),
                      8'($urandom_range(255)));
         queue_access(OP_WRITE, 16'hA000 | 16'(hot_offsets[$urandom_range(7)]),
                      8'($urandom_range(255)));
         queue_access(OP_WRITE, 16'h4000 | 16'($urandom_range(16'h1FFF)),
                      8'($urandom_range(255)));
         queue_access(OP_WRITE, 16'h6000 | 16'($urandom_range(16'h1FFF)),
                      {7'($urandom_range(127)), 1'b0});
      end else begin
         repeat ($urandom_range(1, 4)) begin
            queue_access(($urandom_range(1) == 1) ? OP_WRITE : OP_READ,
                         16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
         end
      end
   endtask

   // Driver: a new transaction goes out at the falling edge once the last one was taken.
   // In about 11 of 100 chances to send, the sender idles, except inside the no-idle window.
   always @(negedge clock) begin
      cart_access_type next_access;
      if (in_reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (pending_access_q.size() != 0 && (no_idle || $urandom_range(99) >= 11)) begin
            next_access = pending_access_q.pop_front();
            req_if.valid      <= 1'b1;
            req_if.opcode     <= next_access.op;
            req_if.address    <= next_access.addr;
            req_if.write_data <= next_access.data;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus two long hold-offs while the sender keeps a deep queue
   // of transactions, so that the block fills up and stalls its input.
   always @(negedge clock) begin
      if (in_reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (holdoff_left == 0 && holdoffs_done < 2 &&
             rsp_count >= holdoff_marks[holdoffs_done] && pending_access_q.size() >= 30) begin
            holdoff_left = 120;
            holdoffs_done++;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= no_idle || ($urandom_range(99) >= 11);
         end
      end
   end

   // Monitor: at each rising edge a taken response is checked against the oldest
   // prediction first, then a taken transaction adds its own prediction.
   always @(posedge clock) begin
      rsp_fields_type want;
      cart_access_type taken;
      in_reset <= reset;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready) begin
            rsp_count <= rsp_count + 1;
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response with no transaction outstanding", 32'(rsp_if.data_source),
                               32'hFFFF_FFFF);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_if.read_data !== want.read_data) begin
                  report_mismatch("read_data", 32'(rsp_if.read_data), 32'(want.read_data));
               end
               if (rsp_if.rom_address !== want.rom_address) begin
                  report_mismatch("rom_address", 32'(rsp_if.rom_address), 32'(want.rom_address));
               end
               if (rsp_if.data_source !== want.source) begin
                  report_mismatch("data_source", 32'(rsp_if.data_source), 32'(want.source));
               end
               if (rsp_if.save_request !== want.save_request) begin
                  report_mismatch("save_request", 32'(rsp_if.save_request),
                                  32'(want.save_request));
               end
            end
         end
         req_fire <= req_if.valid && (req_if.ready === 1'b1);
         if (req_if.valid && req_if.ready === 1'b1) begin
            taken.op   = opcode_type'(req_if.opcode);
            taken.addr = req_if.address;
            taken.data = req_if.write_data;
            expected_rsp_q.push_back(predict_bus_access(taken));
         end
      end
   end

   // Main sequence: reset, directed checks, then the random phases, each phase written
   // while the block is idle and each drained before the next setting goes in.
   initial begin
      setting_type s;
      foreach (ram_image[i]) begin
         ram_image[i] = '0;
      end
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.opcode     = 1'b0;
      req_if.address    = '0;
      req_if.write_data = '0;
      rsp_if.ready      = 1'b0;
      csr_write_enable  = 1'b0;
      csr_index         = '0;
      csr_write_data    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part with banking on, all four RAM banks and a battery.
      s = '{1'b1, 3'd3, 1'b1};
      apply_setting(s);
      queue_access(OP_READ,  16'h0000, 8'h00);
      queue_access(OP_READ,  16'h3FFF, 8'hFF);
      queue_access(OP_READ,  16'h4000, 8'h00);
      queue_access(OP_READ,  16'hA000, 8'h00);   // RAM still disabled: open bus
      queue_access(OP_WRITE, 16'h0000, 8'h0A);
      queue_access(OP_WRITE, 16'hBFFF, 8'hFF);
      queue_access(OP_READ,  16'hBFFF, 8'h00);
      queue_access(OP_WRITE, 16'h2000, 8'h00);   // zero selects bank 1
      queue_access(OP_WRITE, 16'h3FFF, 8'h20);   // masked down to bank 0
      queue_access(OP_READ,  16'h7FFF, 8'h00);
      queue_access(OP_WRITE, 16'h2000, 8'hFF);
      queue_access(OP_READ,  16'hFFFF, 8'h00);   // top of the bus through bank 31
      queue_access(OP_READ,  16'h8000, 8'h00);
      queue_access(OP_WRITE, 16'h4000, 8'h03);   // mode 0: no switch yet
      queue_access(OP_WRITE, 16'h6000, 8'h01);   // switch while dirty
      queue_access(OP_WRITE, 16'hA123, 8'h5A);
      queue_access(OP_READ,  16'hA123, 8'h00);
      queue_access(OP_WRITE, 16'h5FFF, 8'h02);
      queue_access(OP_WRITE, 16'h7FFF, 8'h00);   // back to mode 0 keeps bank 2
      queue_access(OP_READ,  16'hA123, 8'h00);
      queue_access(OP_WRITE, 16'h8000, 8'h77);   // ignored write regions
      queue_access(OP_WRITE, 16'hC000, 8'h77);
      queue_access(OP_WRITE, 16'h1FFF, 8'h00);
      queue_access(OP_READ,  16'hA000, 8'h00);
      wait_drained();

      // With the mapper off, writes change nothing and every read passes through.
      s = '{1'b0, 3'd3, 1'b1};
      apply_setting(s);
      queue_access(OP_WRITE, 16'h0000, 8'h0A);
      queue_access(OP_WRITE, 16'h2000, 8'h05);
      queue_access(OP_READ,  16'h4000, 8'h00);
      queue_access(OP_READ,  16'hA000, 8'h00);
      queue_access(OP_READ,  16'hFFFF, 8'h00);
      wait_drained();

      // A single RAM bank: the active bank 2 is absent until the switch back to bank 0.
      s = '{1'b1, 3'd2, 1'b1};
      apply_setting(s);
      queue_access(OP_WRITE, 16'h0000, 8'hFA);
      queue_access(OP_READ,  16'hA123, 8'h00);
      queue_access(OP_WRITE, 16'hA123, 8'h11);
      queue_access(OP_WRITE, 16'h6000, 8'h01);
      queue_access(OP_WRITE, 16'h4000, 8'h00);
      queue_access(OP_READ,  16'hA123, 8'h00);
      queue_access(OP_WRITE, 16'h1000, 8'h00);
      wait_drained();

      // Random phases.
      foreach (phase_plan[p]) begin
         apply_setting(phase_plan[p]);
         while (phase_items < 92) begin
            queue_random_burst();
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far beyond the RAM clearing pass after reset plus the slowest run.
   initial begin
      #4_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
